// File: rtl/lcs_pkg.sv
// Shared types and constants of the longest common subsequence block.
// No dependencies; the front end, back end and top level import this package.
`timescale 1ns / 1ps

package lcs_pkg;

    localparam int LCS_MAX_LEN = 64;

    // Input opcodes.
    localparam logic [1:0] OP_APPEND_FIRST  = 2'd0;
    localparam logic [1:0] OP_APPEND_SECOND = 2'd1;
    localparam logic [1:0] OP_FINISH        = 2'd2;

    // Commands after classification by the front end.
    typedef enum logic [1:0] {
        CMD_APPEND_FIRST  = 2'd0,
        CMD_APPEND_SECOND = 2'd1,
        CMD_FINISH        = 2'd2
    } cmd_t;

    // Direction codes held in the direction table.
    typedef logic [1:0] dir_t;
    localparam dir_t DIR_MATCH = 2'd0;
    localparam dir_t DIR_UP    = 2'd1;
    localparam dir_t DIR_LEFT  = 2'd2;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] symbol;
    } item_t;

endpackage

// File: rtl/lcs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module lcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/lcs_front.sv
// Front end: accepts input transfers, classifies opcodes and queues commands.
// Depends on lcs_pkg.
`timescale 1ns / 1ps

module lcs_front import lcs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_opcode,
    input  logic [7:0] s_symbol,
    output logic       q_valid,
    input  logic       q_ready,
    output item_t      q_item
);

    item_t      slot_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop, useful;
    item_t      new_item;

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = slot_reg[rptr_reg];

    always_comb begin
        useful = 1'b1;
        new_item.symbol = s_symbol;
        new_item.cmd = CMD_FINISH;
        case (s_opcode)
            OP_APPEND_FIRST:  new_item.cmd = CMD_APPEND_FIRST;
            OP_APPEND_SECOND: new_item.cmd = CMD_APPEND_SECOND;
            OP_FINISH:        new_item.cmd = CMD_FINISH;
            default:          useful = 1'b0;   // unused opcode is discarded
        endcase
    end

    assign push = s_valid && s_ready && useful;
    assign pop  = q_valid && q_ready;

    always_comb begin
        wptr_next  = push ? ~wptr_reg : wptr_reg;
        rptr_next  = pop ? ~rptr_reg : rptr_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
        if (push) begin
            slot_reg[wptr_reg] <= new_item;
        end
    end

endmodule

// File: rtl/lcs_back.sv
// Back end: string storage, table fill, traceback and result emission.
// Depends on lcs_pkg and lcs_ram.
`timescale 1ns / 1ps

module lcs_back import lcs_pkg::*; #(
    parameter int MAX_LEN = LCS_MAX_LEN
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    output logic       q_ready,
    input  item_t      q_item,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_lcs_length,
    output logic [7:0] m_out_symbol,
    output logic       m_symbol_valid,
    output logic       m_last,
    output logic       m_dropped
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int DW = 2 * AW;
    localparam logic [CW-1:0] FULL = CW'(MAX_LEN);
    localparam logic [CW-1:0] ONE  = CW'(1);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_ROW     = 8'b0000_0010,
        S_CELL_RD = 8'b0000_0100,
        S_CELL_EX = 8'b0000_1000,
        S_TB_RD   = 8'b0001_0000,
        S_TB_EX   = 8'b0010_0000,
        S_EM_RD   = 8'b0100_0000,
        S_EM_OUT  = 8'b1000_0000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next;
    logic [CW-1:0] pos_reg, pos_next, k_reg, k_next;
    logic [CW-1:0] left_reg, left_next, diag_reg, diag_next;
    logic [CW-1:0] len_reg, len_next;
    logic          out_valid_reg, out_valid_next;
    logic [6:0]    out_len_reg, out_len_next;
    logic [7:0]    out_sym_reg, out_sym_next;
    logic          out_sv_reg, out_sv_next, out_last_reg, out_last_next;
    logic          out_drop_reg, out_drop_next;

    logic          a_we, b_we, s_we, d_we, q_we;
    logic [AW-1:0] a_waddr, b_waddr, b_raddr, q_waddr;
    logic [CW-1:0] s_addr;
    logic [DW-1:0] d_addr;
    logic [CW-1:0] i_m1, j_m1, pos_m1;
    logic [7:0]    a_rd, b_rd, q_rd;
    logic [CW-1:0] s_rd, val, up_v, left_v, diag_v;
    dir_t          d_rd, d_wr;
    logic          out_free, is_last;

    assign i_m1   = i_reg - ONE;
    assign j_m1   = j_reg - ONE;
    assign pos_m1 = pos_reg - ONE;
    assign d_addr = {i_m1[AW-1:0], j_m1[AW-1:0]};
    assign out_free = !out_valid_reg || m_ready;
    assign q_ready  = (state_reg == S_IDLE);

    lcs_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_first (
        .aclk(aclk), .we(a_we), .waddr(a_waddr), .wdata(q_item.symbol),
        .raddr(i_m1[AW-1:0]), .rdata(a_rd));
    lcs_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_second (
        .aclk(aclk), .we(b_we), .waddr(b_waddr), .wdata(q_item.symbol),
        .raddr(b_raddr), .rdata(b_rd));
    lcs_ram #(.WIDTH(CW), .DEPTH(MAX_LEN + 1), .ADDR_W(CW)) u_score (
        .aclk(aclk), .we(s_we), .waddr(s_addr), .wdata(val),
        .raddr(s_addr), .rdata(s_rd));
    lcs_ram #(.WIDTH(2), .DEPTH(1 << DW), .ADDR_W(DW)) u_dir (
        .aclk(aclk), .we(d_we), .waddr(d_addr), .wdata(d_wr),
        .raddr(d_addr), .rdata(d_rd));
    lcs_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_seq (
        .aclk(aclk), .we(q_we), .waddr(q_waddr), .wdata(a_rd),
        .raddr(k_reg[AW-1:0]), .rdata(q_rd));

    // Cell recurrence: row above comes from the score row, left and diagonal
    // from registers; the top row and left column are zero borders.
    always_comb begin
        up_v   = (i_reg == ONE) ? '0 : s_rd;
        left_v = (j_reg == ONE) ? '0 : left_reg;
        diag_v = (j_reg == ONE) ? '0 : diag_reg;
        if (a_rd == b_rd) begin
            val  = diag_v + ONE;
            d_wr = DIR_MATCH;
        end else if (up_v > left_v) begin
            val  = up_v;
            d_wr = DIR_UP;
        end else begin
            val  = left_v;
            d_wr = DIR_LEFT;
        end
    end

    assign is_last = (len_reg == '0) || ((k_reg + ONE) == len_reg);

    always_comb begin
        state_next = state_reg;
        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        pos_next   = pos_reg;
        k_next     = k_reg;
        left_next  = left_reg;
        diag_next  = diag_reg;
        len_next   = len_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_len_next   = out_len_reg;
        out_sym_next   = out_sym_reg;
        out_sv_next    = out_sv_reg;
        out_last_next  = out_last_reg;
        out_drop_next  = out_drop_reg;
        a_we    = 1'b0;
        b_we    = 1'b0;
        s_we    = 1'b0;
        d_we    = 1'b0;
        q_we    = 1'b0;
        a_waddr = cnt_a_reg[AW-1:0];
        b_waddr = cnt_b_reg[AW-1:0];
        b_raddr = j_m1[AW-1:0];
        s_addr  = j_reg;
        q_waddr = pos_m1[AW-1:0];
        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    case (q_item.cmd)
                        CMD_APPEND_FIRST: begin
                            if (cnt_a_reg == FULL) begin
                                ovf_next = 1'b1;
                            end else begin
                                a_we       = 1'b1;
                                cnt_a_next = cnt_a_reg + ONE;
                            end
                        end
                        CMD_APPEND_SECOND: begin
                            if (cnt_b_reg == FULL) begin
                                ovf_next = 1'b1;
                            end else begin
                                b_we       = 1'b1;
                                cnt_b_next = cnt_b_reg + ONE;
                            end
                        end
                        default: begin
                            k_next   = '0;
                            len_next = '0;
                            i_next   = ONE;
                            j_next   = ONE;
                            if (cnt_a_reg == '0 || cnt_b_reg == '0) begin
                                state_next = S_EM_RD;
                            end else begin
                                state_next = S_ROW;
                            end
                        end
                    endcase
                end
            end
            S_ROW: begin
                state_next = S_CELL_RD;
            end
            S_CELL_RD: begin
                state_next = S_CELL_EX;
            end
            S_CELL_EX: begin
                s_we      = 1'b1;
                d_we      = 1'b1;
                left_next = val;
                diag_next = up_v;
                len_next  = val;
                if (j_reg == cnt_b_reg) begin
                    if (i_reg == cnt_a_reg) begin
                        pos_next   = val;
                        state_next = S_TB_RD;
                    end else begin
                        i_next     = i_reg + ONE;
                        j_next     = ONE;
                        state_next = S_ROW;
                    end
                end else begin
                    j_next     = j_reg + ONE;
                    state_next = S_CELL_RD;
                end
            end
            S_TB_RD: begin
                state_next = S_TB_EX;
            end
            S_TB_EX: begin
                state_next = S_TB_RD;
                if (d_rd == DIR_MATCH) begin
                    q_we     = 1'b1;
                    pos_next = pos_m1;
                    i_next   = i_m1;
                    j_next   = j_m1;
                    if (i_reg == ONE || j_reg == ONE) begin
                        state_next = S_EM_RD;
                    end
                end else if (d_rd == DIR_UP) begin
                    i_next = i_m1;
                    if (i_reg == ONE) begin
                        state_next = S_EM_RD;
                    end
                end else begin
                    j_next = j_m1;
                    if (j_reg == ONE) begin
                        state_next = S_EM_RD;
                    end
                end
            end
            S_EM_RD: begin
                state_next = S_EM_OUT;
            end
            S_EM_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_len_next   = 7'(len_reg);
                    out_sv_next    = (len_reg != '0);
                    out_sym_next   = (len_reg != '0) ? q_rd : 8'd0;
                    out_last_next  = is_last;
                    out_drop_next  = ovf_reg;
                    if (is_last) begin
                        cnt_a_next = '0;
                        cnt_b_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end else begin
                        k_next     = k_reg + ONE;
                        state_next = S_EM_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
        i_reg        <= i_next;
        j_reg        <= j_next;
        pos_reg      <= pos_next;
        k_reg        <= k_next;
        left_reg     <= left_next;
        diag_reg     <= diag_next;
        len_reg      <= len_next;
        out_len_reg  <= out_len_next;
        out_sym_reg  <= out_sym_next;
        out_sv_reg   <= out_sv_next;
        out_last_reg <= out_last_next;
        out_drop_reg <= out_drop_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_lcs_length   = out_len_reg;
    assign m_out_symbol   = out_sym_reg;
    assign m_symbol_valid = out_sv_reg;
    assign m_last         = out_last_reg;
    assign m_dropped      = out_drop_reg;

endmodule

// File: rtl/longest_common_subsequence_top.sv
// Top level of the longest common subsequence block.
// Depends on lcs_pkg, lcs_front, lcs_back (and lcs_ram below it).
`timescale 1ns / 1ps

// Symbols are appended one transfer at a time to a first string (opcode 0)
// or a second string (opcode 1), each holding up to MAX_LEN symbols; further
// appends are dropped and flagged on the results. Opcode 2 finishes: the
// score and direction tables are filled one cell at a time, with an extra
// row-start state at the start of each row, the trace walks back from the
// bottom-right corner preferring a step along the second string on a tie,
// one step at a time, and the subsequence is then emitted in forward order,
// one result transfer per symbol, each held until the output is free, with
// last on the final one. An empty subsequence gives a single transfer with
// symbol_valid low. Each cell, trace step and emitted symbol is preceded by
// a read state for the registered reads of the string, score row, direction
// and sequence memories. A two-entry queue separates the accepting front end
// from the back end, which takes queued commands only while idle, so appends
// are taken while a finish runs until the queue fills; opcode 3 is accepted
// and ignored. Both strings and the drop flag clear after each finish.
module longest_common_subsequence_top import lcs_pkg::*; #(
    parameter int MAX_LEN = LCS_MAX_LEN
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_opcode,
    input  logic [7:0] s_symbol,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_lcs_length,
    output logic [7:0] m_out_symbol,
    output logic       m_symbol_valid,
    output logic       m_last,
    output logic       m_dropped
);

    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    lcs_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_opcode(s_opcode), .s_symbol(s_symbol),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    lcs_back #(.MAX_LEN(MAX_LEN)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_lcs_length(m_lcs_length), .m_out_symbol(m_out_symbol),
        .m_symbol_valid(m_symbol_valid), .m_last(m_last),
        .m_dropped(m_dropped)
    );

endmodule

// File: sim/longest_common_subsequence_top_tb.sv
// Self-checking testbench for longest_common_subsequence_top.
// Depends on lcs_pkg and the block's RTL; it needs no other file.
`timescale 1ns / 1ps

module longest_common_subsequence_top_tb;
    import lcs_pkg::*;

    localparam int  MAXL        = LCS_MAX_LEN;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  TAIL_CYCLES = 200;
    localparam int  ITEM_TARGET = 470;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // One input transfer waiting to be driven. A drain mark makes the
    // sender pause until every expected result has arrived.
    typedef struct {
        logic [1:0] opcode;
        logic [7:0] symbol;
        bit         drain;
    } stim_t;

    // One result transfer as the block should produce it.
    typedef struct packed {
        logic [6:0] length;
        logic [7:0] symbol;
        logic       sym_valid;
        logic       last;
        logic       dropped;
    } lcs_result_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_opcode = '0;
    logic [7:0] s_symbol = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [6:0] m_lcs_length;
    logic [7:0] m_out_symbol;
    logic       m_symbol_valid;
    logic       m_last;
    logic       m_dropped;

    stim_t       pending_items[$];
    lcs_result_t expected_subseq[$];
    int          cycle_count = 0;
    int          mismatch_count = 0;
    bit          in_taken = 1'b0;
    bit          hold_started = 1'b0;
    int          hold_left = 0;

    // Shadow state of the block: the two strings and the drop flag.
    logic [7:0] first_str[MAXL];
    logic [7:0] second_str[MAXL];
    int         first_len = 0;
    int         second_len = 0;
    bit         overflow = 1'b0;

    always #5 aclk = ~aclk;

    longest_common_subsequence_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_symbol       (s_symbol),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_lcs_length   (m_lcs_length),
        .m_out_symbol   (m_out_symbol),
        .m_symbol_valid (m_symbol_valid),
        .m_last         (m_last),
        .m_dropped      (m_dropped)
    );

    // Random idling is suspended over a fixed window so that the block also
    // sees back-to-back transfers on both sides.
    function automatic bit idle_now();
        if (cycle_count >= 2000 && cycle_count < 6000) begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < 27;
    endfunction

    // Applies one accepted transfer to the shadow state and, for a finish,
    // works out the subsequence with the same tie rule as the block: a step
    // along the second string unless the upper score is strictly larger.
    task automatic apply_transfer(input logic [1:0] opcode, input logic [7:0] symbol);
        int          score[MAXL + 1][MAXL + 1];
        logic [1:0]  dir[MAXL + 1][MAXL + 1];
        logic [7:0]  subseq[MAXL];
        int          len;
        int          pos;
        int          i;
        int          j;
        lcs_result_t res;
        case (opcode)
            OP_APPEND_FIRST: begin
                if (first_len >= MAXL) begin
                    overflow = 1'b1;
                end else begin
                    first_str[first_len] = symbol;
                    first_len++;
                end
            end
            OP_APPEND_SECOND: begin
                if (second_len >= MAXL) begin
                    overflow = 1'b1;
                end else begin
                    second_str[second_len] = symbol;
                    second_len++;
                end
            end
            OP_FINISH: begin
                for (i = 0; i <= first_len; i++) begin
                    for (j = 0; j <= second_len; j++) begin
                        if (i == 0 || j == 0) begin
                            score[i][j] = 0;
                        end else if (first_str[i - 1] == second_str[j - 1]) begin
                            score[i][j] = score[i - 1][j - 1] + 1;
                            dir[i][j] = DIR_MATCH;
                        end else if (score[i - 1][j] > score[i][j - 1]) begin
                            score[i][j] = score[i - 1][j];
                            dir[i][j] = DIR_UP;
                        end else begin
                            score[i][j] = score[i][j - 1];
                            dir[i][j] = DIR_LEFT;
                        end
                    end
                end
                len = score[first_len][second_len];
                pos = len;
                i = first_len;
                j = second_len;
                while (i > 0 && j > 0) begin
                    if (dir[i][j] == DIR_MATCH) begin
                        pos--;
                        subseq[pos] = first_str[i - 1];
                        i--;
                        j--;
                    end else if (dir[i][j] == DIR_UP) begin
                        i--;
                    end else begin
                        j--;
                    end
                end
                if (len == 0) begin
                    res = '{length: 7'd0, symbol: 8'd0, sym_valid: 1'b0, last: 1'b1,
                            dropped: overflow};
                    expected_subseq.push_back(res);
                end else begin
                    for (int k = 0; k < len; k++) begin
                        res = '{length: 7'(len), symbol: subseq[k], sym_valid: 1'b1,
                                last: (k == len - 1), dropped: overflow};
                        expected_subseq.push_back(res);
                    end
                end
                first_len = 0;
                second_len = 0;
                overflow = 1'b0;
            end
            default: ;
        endcase
    endtask

    task automatic add_item(input logic [1:0] opcode, input logic [7:0] symbol,
                            input bit drain = 1'b0);
        stim_t it;
        it.opcode = opcode;
        it.symbol = symbol;
        it.drain = drain;
        pending_items.push_back(it);
    endtask

    // Builds one finish sequence: the two strings appended in random order
    // from a mostly narrow alphabet so that matches are common, with the odd
    // unused opcode mixed in as noise.
    task automatic add_sequence(input int len_a, input int len_b, input bit drain);
        int         na;
        int         nb;
        int         span;
        logic [7:0] base;
        na = 0;
        nb = 0;
        base = 8'($urandom);
        span = $urandom_range(0, 3) == 0 ? 255 : $urandom_range(1, 5);
        while (na < len_a || nb < len_b) begin
            if ($urandom_range(0, 29) == 0) begin
                add_item(OP_UNUSED, 8'($urandom));
            end
            if (nb >= len_b || (na < len_a && $urandom_range(0, 1) == 0)) begin
                add_item(OP_APPEND_FIRST, base + 8'($urandom_range(0, span)));
                na++;
            end else begin
                add_item(OP_APPEND_SECOND, base + 8'($urandom_range(0, span)));
                nb++;
            end
        end
        add_item(OP_FINISH, 8'($urandom), drain);
    endtask

    // Flags a transfer that was accepted at this edge so that the driver,
    // on the falling edge, knows the payload may change.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        in_taken <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            apply_transfer(s_opcode, s_symbol);
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL longest_common_subsequence_top");
            $finish;
        end
    end

    // Sender: inputs move only on the falling edge, and a valid item is
    // held until the transfer has taken place.
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || in_taken)) begin
            if (pending_items.size() == 0 || idle_now() ||
                (pending_items[0].drain && expected_subseq.size() != 0)) begin
                s_valid <= 1'b0;
            end else begin
                s_valid <= 1'b1;
                s_opcode <= pending_items[0].opcode;
                s_symbol <= pending_items[0].symbol;
                void'(pending_items.pop_front());
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off started the
    // first time results are offered, so that a finish stalls on its output
    // while appends pile up behind it and the input stalls in turn.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (!hold_started && m_valid) begin
            hold_started <= 1'b1;
            hold_left <= 400;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !idle_now();
        end
    end

    // Each result transfer is checked against the oldest expectation.
    always @(posedge aclk) begin
        lcs_result_t got;
        lcs_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{length: m_lcs_length, symbol: m_out_symbol, sym_valid: m_symbol_valid,
                    last: m_last, dropped: m_dropped};
            if (expected_subseq.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("Unexpected result transfer: len=%0d sym=%0h valid=%0b last=%0b drop=%0b",
                             got.length, got.symbol, got.sym_valid, got.last, got.dropped);
                end
            end else begin
                want = expected_subseq.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("Mismatch: expected len=%0d sym=%0h valid=%0b last=%0b drop=%0b, got len=%0d sym=%0h valid=%0b last=%0b drop=%0b",
                                 want.length, want.symbol, want.sym_valid, want.last,
                                 want.dropped, got.length, got.symbol, got.sym_valid,
                                 got.last, got.dropped);
                    end
                end
            end
        end
    end

    initial begin
        int seq_no;
        int la;
        int lb;
        // Directed part: empty finishes, byte extremes, a tie, noise opcode.
        add_item(OP_FINISH, 8'hFF);
        add_item(OP_APPEND_FIRST, 8'h00);
        add_item(OP_FINISH, 8'h00);
        add_item(OP_APPEND_FIRST, 8'h00);
        add_item(OP_APPEND_FIRST, 8'hFF);
        add_item(OP_APPEND_SECOND, 8'h00);
        add_item(OP_APPEND_SECOND, 8'hFF);
        add_item(OP_FINISH, 8'h55);
        add_item(OP_APPEND_FIRST, 8'hAA);
        add_item(OP_APPEND_FIRST, 8'h55);
        add_item(OP_APPEND_SECOND, 8'h55);
        add_item(OP_APPEND_SECOND, 8'hAA);
        add_item(OP_UNUSED, 8'hFF);
        add_item(OP_FINISH, 8'hAA);
        add_item(OP_APPEND_SECOND, 8'h7F);
        add_item(OP_UNUSED, 8'h00);
        add_item(OP_FINISH, 8'h00, 1'b1);

        // Random part: mostly short sequences, two that fill the first string, one
        // of them running past capacity on both strings.
        seq_no = 0;
        while (pending_items.size() < ITEM_TARGET) begin
            if (seq_no == 4) begin
                la = MAXL + 3;
                lb = MAXL + 1;
            end else if (seq_no == 12) begin
                la = MAXL;
                lb = 12;
            end else begin
                la = $urandom_range(0, 8);
                lb = $urandom_range(0, 8);
            end
            add_sequence(la, lb, seq_no == 9);
            seq_no++;
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() != 0 || s_valid) begin
            @(negedge aclk);
        end
        while (expected_subseq.size() != 0) begin
            @(negedge aclk);
        end
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (mismatch_count == 0 && expected_subseq.size() == 0) begin
            $display("PASS longest_common_subsequence_top");
        end else begin
            $display("FAIL longest_common_subsequence_top");
        end
        $finish;
    end

endmodule
